@@ sv/sfad_pkg.sv @@
// Shared constants and types for the spectrum frame average and decimate block.
`timescale 1ns / 1ps
`default_nettype none

package sfad_pkg;

    // Parameter defaults
    localparam int BINS_PER_FRAME_DEF = 8192;
    localparam int MAX_PIXELS_DEF     = 1024;
    localparam int MAX_FRAMES_DEF     = 31;
    localparam int MAX_GROUP_DEF      = 16;

    // Field widths
    localparam int POWER_W   = 24;
    localparam int HSYM_W    = 9;
    localparam int PTIME_W   = 21;
    localparam int VALUE_W   = 32;
    localparam int PIX_IDX_W = 10;
    localparam int MARK_W    = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    // Configuration registers
    localparam int FTA_W   = 5;
    localparam int BPP_W   = 5;
    localparam int START_W = 13;
    localparam int PCNT_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_COUNT = 2'd3;

    localparam logic [FTA_W-1:0]   FTA_RST   = 5'd2;
    localparam logic [BPP_W-1:0]   BPP_RST   = 5'd8;
    localparam logic [START_W-1:0] START_RST = 13'd0;
    localparam logic [PCNT_W-1:0]  PCNT_RST  = 11'd1024;

    // Input item kinds
    localparam logic OP_BIN = 1'b0;
    localparam logic OP_TX  = 1'b1;

    // Period marks
    localparam logic [MARK_W-1:0] MARK_NONE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_NEW  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TX   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ sv/spectrum_frame_average_decimate_top.sv @@
// Spectrum frame averaging with bin decimation into display pixels.
//
// Bins enter one item at a time; each per-bin running sum lives in a single-port
// synchronous memory of BINS_PER_FRAME words, read on accept and written back in
// the accumulate cycle that follows. A bin that closes a pixel group goes on to
// the multiply state, PROD_W steps (38 at default sizes) of the one-bit-per-cycle
// restoring divider that divides group size times group sum by the frame count,
// and the done state, which waits on a stalled output. Other bins and transmission
// items leave the block ready. The sum memory is not cleared at reset; the first
// frame after reset writes every bin it covers.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_frame_average_decimate_top
    import sfad_pkg::*;
#(
    parameter int BINS_PER_FRAME = BINS_PER_FRAME_DEF,
    parameter int MAX_PIXELS     = MAX_PIXELS_DEF,
    parameter int MAX_FRAMES     = MAX_FRAMES_DEF,
    parameter int MAX_GROUP      = MAX_GROUP_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // slave side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // bin_power[23:0], from_disk[24], half_symbol_index[33:25], period_time_ms[54:34]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,   // op[0]
    input  wire logic                  s_tlast,   // last_bin
    // master side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_value[31:0], pixel_index[41:32]
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [MARK_W-1:0]          m_tuser,   // period_mark[1:0]
    output logic                       m_tlast,   // last_pixel
    // configuration
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int F_MAX  = (MAX_FRAMES < (1 << FTA_W) - 1) ? MAX_FRAMES : (1 << FTA_W) - 1;
    localparam int G_MAX  = (MAX_GROUP < (1 << BPP_W) - 1) ? MAX_GROUP : (1 << BPP_W) - 1;
    localparam int SUM_W  = POWER_W + $clog2(F_MAX + 1);
    localparam int GSUM_W = SUM_W + $clog2(G_MAX);
    localparam int GV_W   = $clog2(G_MAX + 1);
    localparam int BIG_W  = (G_MAX > 1) ? $clog2(G_MAX) : 1;
    localparam int A_W    = $clog2(BINS_PER_FRAME);
    localparam int POS_W  = $clog2(BINS_PER_FRAME + 1);
    localparam int P_W    = $clog2(MAX_PIXELS + 1);
    localparam int PROD_W = GSUM_W + GV_W;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int MUL_W  = P_W + 1 + GV_W;
    localparam int CMP_W  = (MUL_W > POS_W) ? MUL_W : POS_W;

    // configuration registers
    logic [FTA_W-1:0]   fta_reg;
    logic [BPP_W-1:0]   bpp_reg;
    logic [START_W-1:0] start_reg;
    logic [PCNT_W-1:0]  pcnt_reg;

    // control state
    state_t             state_reg, state_next;
    logic [FTA_W-1:0]   frames_seen_reg;
    logic [POS_W-1:0]   bin_pos_reg;
    logic [GSUM_W-1:0]  group_sum_reg;
    logic [BIG_W-1:0]   big_reg;
    logic [P_W-1:0]     pix_pos_reg;
    logic               tx_pend_reg;
    logic [PTIME_W-1:0] prev_time_reg;
    logic [MARK_W-1:0]  frame_mark_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               m_valid_reg;

    // payload registers
    logic [POWER_W-1:0]   pwr_reg;
    logic                 last_reg;
    logic                 disk_reg;
    logic [HSYM_W-1:0]    hsym_reg;
    logic [PTIME_W-1:0]   ptime_reg;
    logic [SUM_W-1:0]     rd_data_reg;
    logic [GSUM_W-1:0]    mul_a_reg;
    logic [GV_W-1:0]      mul_g_reg;
    logic [FTA_W-1:0]     div_n_reg;
    logic [PROD_W-1:0]    div_reg;
    logic [FTA_W-1:0]     rem_reg;
    logic [PIX_IDX_W-1:0] idx_reg;
    logic [MARK_W-1:0]    mark_out_reg;
    logic                 lastpx_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [MARK_W-1:0]    m_user_reg;
    logic                 m_last_reg;

    logic [SUM_W-1:0] sum_mem [BINS_PER_FRAME];

    // control strobes
    logic in_fire, acc_en, mul_en, div_en, load_out;

    // effective configuration
    logic [FTA_W-1:0]  f_eff;
    logic [GV_W-1:0]   g_eff;
    logic [P_W-1:0]    pcap;
    logic              start_ok;
    logic [CMP_W-1:0]  room;
    logic [FTA_W:0]    n_ext;
    logic              averaging;

    // accumulate step
    logic              pos_in_frame;
    logic [SUM_W-1:0]  total;
    logic [GSUM_W-1:0] gs_new;
    logic [CMP_W-1:0]  need1, need2;
    logic              in_range;
    logic              grp_active;
    logic              grp_done;
    logic              emit;
    logic              last_px;
    logic              mark_hit;
    logic [MARK_W-1:0] mark_cur;

    // divider step
    logic [FTA_W:0]    rem_sh;
    logic              q_bit;
    logic [PROD_W-1:0] prod;
    logic [VALUE_W-1:0] value;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (fta_reg == '0) begin
            f_eff = FTA_W'(1);
        end else if (int'(fta_reg) > F_MAX) begin
            f_eff = FTA_W'(F_MAX);
        end else begin
            f_eff = fta_reg;
        end
        if (bpp_reg == '0) begin
            g_eff = GV_W'(1);
        end else if (int'(bpp_reg) > G_MAX) begin
            g_eff = GV_W'(G_MAX);
        end else begin
            g_eff = GV_W'(bpp_reg);
        end
        pcap     = (int'(pcnt_reg) > MAX_PIXELS) ? P_W'(MAX_PIXELS) : P_W'(pcnt_reg);
        start_ok = int'(start_reg) < BINS_PER_FRAME;
        room     = start_ok ? CMP_W'(BINS_PER_FRAME) - CMP_W'(start_reg) : '0;
        n_ext    = {1'b0, frames_seen_reg} + (FTA_W + 1)'(1);
        averaging = n_ext >= {1'b0, f_eff};
    end

    always_comb begin
        pos_in_frame = int'(bin_pos_reg) < BINS_PER_FRAME;
        mark_hit = (disk_reg && hsym_reg <= HSYM_W'(fta_reg)) ||
                   (!disk_reg && ptime_reg < prev_time_reg);
        if (averaging && bin_pos_reg == '0) begin
            mark_cur = mark_hit ? (tx_pend_reg ? MARK_TX : MARK_NEW) : MARK_NONE;
        end else begin
            mark_cur = frame_mark_reg;
        end
        total  = (frames_seen_reg == '0) ? SUM_W'(pwr_reg) : rd_data_reg + SUM_W'(pwr_reg);
        gs_new = group_sum_reg + GSUM_W'(total);
        need1  = (CMP_W'(pix_pos_reg) + CMP_W'(1)) * CMP_W'(g_eff);
        need2  = (CMP_W'(pix_pos_reg) + CMP_W'(2)) * CMP_W'(g_eff);
        in_range = (pix_pos_reg < pcap) && start_ok && (need1 <= room);
        grp_active = averaging && pos_in_frame &&
                     (int'(bin_pos_reg) >= int'(start_reg)) && in_range;
        grp_done = (int'(big_reg) + 1) >= int'(g_eff);
        emit     = grp_active && grp_done;
        last_px  = ((pix_pos_reg + P_W'(1)) == pcap) || (need2 > room);
    end

    always_comb begin
        rem_sh = {rem_reg, div_reg[PROD_W-1]};
        q_bit  = rem_sh >= {1'b0, div_n_reg};
        prod   = mul_a_reg * mul_g_reg;
        if (mark_out_reg != MARK_NONE) begin
            value = '0;
        end else if ((div_reg >> VALUE_W) != '0) begin
            value = '1;
        end else begin
            value = VALUE_W'(div_reg);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == OP_BIN) state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = emit ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(PROD_W - 1)) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready = 1'b0;
        acc_en   = 1'b0;
        mul_en   = 1'b0;
        div_en   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_ACC:  acc_en   = 1'b1;
            ST_MUL:  mul_en   = 1'b1;
            ST_DIV:  div_en   = 1'b1;
            ST_DONE: load_out = !m_valid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
        in_fire = s_tvalid && s_tready;
    end

    // accumulator memory
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            rd_data_reg <= sum_mem[bin_pos_reg[A_W-1:0]];
        end
        if (acc_en && pos_in_frame) begin
            sum_mem[bin_pos_reg[A_W-1:0]] <= total;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fta_reg         <= FTA_RST;
            bpp_reg         <= BPP_RST;
            start_reg       <= START_RST;
            pcnt_reg        <= PCNT_RST;
            frames_seen_reg <= '0;
            bin_pos_reg     <= '0;
            group_sum_reg   <= '0;
            big_reg         <= '0;
            pix_pos_reg     <= '0;
            tx_pend_reg     <= 1'b0;
            prev_time_reg   <= '0;
            frame_mark_reg  <= MARK_NONE;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_FRAMES:    fta_reg   <= cfg_data[FTA_W-1:0];
                    CFG_BPP:       bpp_reg   <= cfg_data[BPP_W-1:0];
                    CFG_START:     start_reg <= cfg_data[START_W-1:0];
                    CFG_PIX_COUNT: pcnt_reg  <= cfg_data[PCNT_W-1:0];
                    default:       ;
                endcase
            end
            if (in_fire && s_tuser == OP_TX) begin
                tx_pend_reg <= 1'b1;
            end
            if (acc_en) begin
                if (averaging && bin_pos_reg == '0) begin
                    prev_time_reg <= ptime_reg;
                    if (mark_hit) tx_pend_reg <= 1'b0;
                end
                if (last_reg) begin
                    bin_pos_reg     <= '0;
                    group_sum_reg   <= '0;
                    big_reg         <= '0;
                    pix_pos_reg     <= '0;
                    frame_mark_reg  <= MARK_NONE;
                    frames_seen_reg <= averaging ? '0 : n_ext[FTA_W-1:0];
                end else begin
                    frame_mark_reg <= mark_cur;
                    if (pos_in_frame) bin_pos_reg <= bin_pos_reg + POS_W'(1);
                    if (grp_active) begin
                        if (grp_done) begin
                            pix_pos_reg   <= pix_pos_reg + P_W'(1);
                            group_sum_reg <= '0;
                            big_reg       <= '0;
                        end else begin
                            group_sum_reg <= gs_new;
                            big_reg       <= big_reg + BIG_W'(1);
                        end
                    end
                end
            end
            if (mul_en) begin
                cnt_reg <= '0;
            end else if (div_en) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pwr_reg   <= s_tdata[POWER_W-1:0];
            disk_reg  <= s_tdata[POWER_W];
            hsym_reg  <= s_tdata[POWER_W+1 +: HSYM_W];
            ptime_reg <= s_tdata[POWER_W+1+HSYM_W +: PTIME_W];
            last_reg  <= s_tlast;
        end
        if (acc_en) begin
            mul_a_reg    <= gs_new;
            mul_g_reg    <= g_eff;
            div_n_reg    <= n_ext[FTA_W-1:0];
            idx_reg      <= PIX_IDX_W'(pix_pos_reg);
            mark_out_reg <= mark_cur;
            lastpx_reg   <= last_px;
        end
        if (mul_en) begin
            div_reg <= prod;
            rem_reg <= '0;
        end else if (div_en) begin
            div_reg <= {div_reg[PROD_W-2:0], q_bit};
            rem_reg <= q_bit ? FTA_W'(rem_sh - {1'b0, div_n_reg}) : rem_sh[FTA_W-1:0];
        end
        if (load_out) begin
            m_data_reg <= M_TDATA_W'({idx_reg, value});
            m_user_reg <= mark_out_reg;
            m_last_reg <= lastpx_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

@@ sv/sfad_checker.sv @@
// Port-level checks for the spectrum frame average and decimate block.
`timescale 1ns / 1ps
`default_nettype none

module sfad_checker
    import sfad_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [MARK_W-1:0]    m_tuser,
    input wire logic                 m_tlast
);

    // a bin item occupies the block for at least its accumulate cycle
    a_bin_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == OP_BIN) |=> !s_tready)
        else $error("input ready right after a bin item");

    // marked pixels carry a zero value
    a_mark_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != MARK_NONE) |-> (m_tdata[VALUE_W-1:0] == '0))
        else $error("marked pixel with nonzero value");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output item changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind spectrum_frame_average_decimate_top sfad_checker u_sfad_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for spectrum_frame_average_decimate_top.
`timescale 1ns / 1ps

module testbench;
    import sfad_pkg::*;

    localparam int BINS          = BINS_PER_FRAME_DEF;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int PHASE_ITEMS   = 85;

    typedef struct {
        bit           op;
        bit [23:0]    power;
        bit           last;
        bit           disk;
        bit [8:0]     hsym;
        bit [20:0]    ptime;
    } bin_item_t;

    typedef struct {
        bit [31:0]    value;
        bit [9:0]     index;
        bit [1:0]     mark;
        bit           last;
    } pixel_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_BIN;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [MARK_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAMES;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    spectrum_frame_average_decimate_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register shadow, shared by the stimulus planner and the pixel predictor
    bit [4:0]  cfg_frames = FTA_RST;
    bit [4:0]  cfg_group  = BPP_RST;
    bit [12:0] cfg_start  = START_RST;
    bit [10:0] cfg_pixels = PCNT_RST;

    // pixel predictor state
    bit [28:0] bin_acc [0:BINS-1];
    bit [4:0]  frames_seen  = '0;
    bit [13:0] bin_pos      = '0;
    bit [32:0] grp_sum      = '0;
    bit [4:0]  grp_bins     = '0;
    bit [10:0] pix_pos      = '0;
    bit        tx_pending   = 1'b0;
    bit [20:0] prev_ptime   = '0;
    bit [1:0]  frame_mark   = MARK_NONE;

    pixel_t    pixels_due[$];
    bin_item_t pending[$];
    bin_item_t held;

    // stimulus planner state
    int unsigned gen_seen   = 0;
    int unsigned gen_filled = 0;
    int unsigned gen_items  = 0;
    bit [20:0]   gen_ptime  = '0;

    int unsigned items_sent = 0, tx_seen = 0, pixels_checked = 0, marked_seen = 0;
    int unsigned fail_count = 0, cfg_writes = 0, settings_used = 0;
    int unsigned send_gap = 0, rdy_gap = 0, tx_calm = 0, rx_calm = 0;
    int unsigned hold_left = 0, idle_cycles = 0;
    bit          want_hold = 1'b0, hold_done = 1'b0;

    function automatic bit [4:0] frames_per_avg();
        return (cfg_frames == 0) ? 5'd1 : cfg_frames;
    endfunction

    function automatic bit [4:0] group_size();
        if (cfg_group == 0) return 5'd1;
        if (cfg_group > MAX_GROUP_DEF) return 5'(MAX_GROUP_DEF);
        return cfg_group;
    endfunction

    function automatic bit [10:0] column_limit(bit [4:0] g);
        bit [13:0] fit;
        bit [10:0] lim;
        lim = (cfg_pixels > MAX_PIXELS_DEF) ? 11'(MAX_PIXELS_DEF) : cfg_pixels;
        fit = 14'((BINS - cfg_start) / g);
        if (lim > fit) lim = fit[10:0];
        return lim;
    endfunction

    function automatic void predict_item(bin_item_t it);
        bit [5:0]  n;
        bit        averaging;
        bit        new_period;
        bit [28:0] total;
        bit [4:0]  g;
        bit [10:0] lim;
        bit [37:0] quo;
        pixel_t    px;
        n = {1'b0, frames_seen} + 6'd1;
        averaging = (n >= frames_per_avg());
        if (it.op == OP_TX) begin
            tx_pending = 1'b1;
            return;
        end
        if (averaging && bin_pos == 0) begin
            new_period = (it.disk && it.hsym <= cfg_frames) || (!it.disk && it.ptime < prev_ptime);
            frame_mark = MARK_NONE;
            if (new_period) begin
                frame_mark = tx_pending ? MARK_TX : MARK_NEW;
                tx_pending = 1'b0;
            end
            prev_ptime = it.ptime;
        end
        if (bin_pos < BINS) begin
            total = (frames_seen == 0) ? it.power : bin_acc[bin_pos[12:0]] + it.power;
            bin_acc[bin_pos[12:0]] = total;
            if (averaging && bin_pos >= cfg_start) begin
                g = group_size();
                lim = column_limit(g);
                if (pix_pos < lim) begin
                    grp_sum += total;
                    if (grp_bins + 1 >= g) begin
                        quo = (g * grp_sum) / n;
                        px.value = (quo > 38'hFFFFFFFF) ? 32'hFFFFFFFF : quo[31:0];
                        if (frame_mark != MARK_NONE) px.value = '0;
                        px.index = pix_pos[9:0];
                        px.mark  = frame_mark;
                        px.last  = (pix_pos + 1 == lim);
                        pixels_due.push_back(px);
                        pix_pos++;
                        grp_sum  = '0;
                        grp_bins = '0;
                    end else begin
                        grp_bins++;
                    end
                end
            end
            bin_pos++;
        end
        if (it.last) begin
            bin_pos    = '0;
            grp_sum    = '0;
            grp_bins   = '0;
            pix_pos    = '0;
            frame_mark = MARK_NONE;
            frames_seen = averaging ? 5'd0 : n[4:0];
        end
    endfunction

    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // item driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(held);
                items_sent++;
                if (held.op == OP_TX) tx_seen++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending.size() != 0) begin
                    held = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, held.ptime, held.hsym, held.disk, held.power};
                    s_tuser  <= held.op;
                    s_tlast  <= held.last;
                    send_gap <= pick_gap(tx_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, fired once
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (want_hold && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // pixel monitor
    always @(posedge aclk) begin
        pixel_t      exp_px;
        int unsigned g;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_gap  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixels_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected pixel: value %h index %0d mark %0d last %0d",
                                 m_tdata[31:0], m_tdata[41:32], m_tuser, m_tlast);
                end else begin
                    exp_px = pixels_due.pop_front();
                    pixels_checked++;
                    if (exp_px.mark != MARK_NONE) marked_seen++;
                    if (m_tdata[31:0] !== exp_px.value || m_tdata[41:32] !== exp_px.index ||
                        m_tuser !== exp_px.mark || m_tlast !== exp_px.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("pixel mismatch: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                     exp_px.value, exp_px.index, exp_px.mark, exp_px.last,
                                     m_tdata[31:0], m_tdata[41:32], m_tuser, m_tlast);
                    end
                end
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                g = pick_gap(rx_calm);
                m_tready <= (g == 0);
                rdy_gap  <= (g == 0) ? 0 : g - 1;
            end else if (rdy_gap != 0) begin
                m_tready <= 1'b0;
                rdy_gap  <= rdy_gap - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_MAX) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_MAX);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [12:0] val);
        bit [12:0] junk;
        bit [12:0] data;
        junk = 13'($urandom);
        case (idx)
            CFG_FRAMES, CFG_BPP: data = (junk & ~13'h1F) | (val & 13'h1F);
            CFG_PIX_COUNT:       data = (junk & ~13'h7FF) | (val & 13'h7FF);
            default:             data = val;
        endcase
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAMES:    cfg_frames = data[4:0];
            CFG_BPP:       cfg_group  = data[4:0];
            CFG_START:     cfg_start  = data[12:0];
            CFG_PIX_COUNT: cfg_pixels = data[10:0];
        endcase
        cfg_writes++;
    endtask

    task automatic configure(bit [12:0] frames, bit [12:0] group, bit [12:0] start,
                             bit [12:0] pixels);
        write_reg(CFG_FRAMES, frames);
        write_reg(CFG_BPP, group);
        write_reg(CFG_START, start);
        write_reg(CFG_PIX_COUNT, pixels);
        settings_used++;
    endtask

    // wait out all pixels, then the tail of any bin still in the pipe
    task automatic settle();
        while (pending.size() != 0 || s_tvalid || pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic bit [23:0] pick_power(bit maxed);
        if (maxed) return '1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic bit [8:0] pick_hsym();
        return ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 40)) :
                                             9'($urandom_range(0, 511));
    endfunction

    function automatic bit [20:0] next_ptime();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) gen_ptime = 21'($urandom_range(0, gen_ptime));
        else if (r < 25) gen_ptime = 21'($urandom_range(0, 1799999));
        else if (gen_ptime > 1799999 - 60000) gen_ptime = 21'(1799999);
        else gen_ptime = gen_ptime + 21'($urandom_range(0, 60000));
        return gen_ptime;
    endfunction

    task automatic push_tx();
        bin_item_t it;
        it.op    = OP_TX;
        it.power = 24'($urandom);
        it.last  = 1'($urandom);
        it.disk  = 1'($urandom);
        it.hsym  = 9'($urandom);
        it.ptime = 21'($urandom);
        pending.push_back(it);
        gen_items++;
    endtask

    // a frame never reads an accumulator that no earlier frame wrote
    task automatic push_frame(int unsigned len, bit disk, bit [8:0] hsym, bit [20:0] ptime,
                              bit maxed, int unsigned tx_pct, bit jitter);
        bin_item_t   it;
        int unsigned i;
        int unsigned n;
        if (gen_seen != 0 && len > gen_filled) len = gen_filled;
        if (len == 0) len = 1;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < tx_pct) push_tx();
            it.op    = OP_BIN;
            it.power = pick_power(maxed);
            it.last  = (i == len - 1);
            it.disk  = disk;
            it.hsym  = hsym;
            it.ptime = ptime;
            if (jitter && i != 0) begin
                it.disk  = 1'($urandom);
                it.hsym  = 9'($urandom);
                it.ptime = 21'($urandom_range(0, 1799999));
            end
            pending.push_back(it);
            gen_items++;
        end
        if (len > gen_filled) gen_filled = (len > BINS) ? BINS : len;
        n = gen_seen + 1;
        gen_seen = (n >= frames_per_avg()) ? 0 : n;
    endtask

    task automatic random_phase(int unsigned items);
        int unsigned base, g, shown, full, len, r;
        base = gen_items;
        while (gen_items - base < items) begin
            g = group_size();
            shown = column_limit(group_size());
            if (shown > 6) shown = 6;
            full = cfg_start + g * shown;
            r = $urandom_range(0, 99);
            if (r < 70) len = full + $urandom_range(0, 3);
            else if (r < 85) len = $urandom_range(1, full + 1);
            else len = $urandom_range(1, 40);
            push_frame(len, $urandom_range(0, 99) < 40, pick_hsym(), next_ptime(), 1'b0, 4,
                       $urandom_range(0, 99) < 8);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: marks, short frame, full-scale powers
        configure(1, 2, 0, 3);
        push_tx();
        push_frame(8, 1'b1, 9'd0, 21'd100, 1'b1, 0, 1'b0);
        push_frame(4, 1'b0, 9'd511, 21'd50, 1'b1, 0, 1'b0);
        push_frame(5, 1'b0, 9'd511, 21'd1799999, 1'b1, 0, 1'b0);
        push_frame(4, 1'b1, 9'd2, 21'd0, 1'b0, 0, 1'b0);
        settle();

        // largest pixel value, surplus bins after the column
        configure(0, 31, 0, 1);
        push_frame(16, 1'b0, 9'd0, 21'd200, 1'b1, 0, 1'b0);
        push_frame(20, 1'b0, 9'd0, 21'd300, 1'b1, 0, 1'b0);
        settle();

        // no whole group fits, then an empty column
        configure(1, 2, 8191, 1024);
        push_frame(8, 1'b0, 9'd7, 21'd600, 1'b0, 0, 1'b0);
        settle();
        configure(1, 2, 0, 0);
        push_frame(6, 1'b0, 9'd7, 21'd700, 1'b0, 0, 1'b0);
        settle();

        configure(2, 4, 0, 4);
        random_phase(PHASE_ITEMS);
        want_hold <= 1'b1;
        settle();
        configure(31, 1, 3, 2);
        random_phase(PHASE_ITEMS);
        settle();
        configure(1, 16, 5, 1024);
        random_phase(PHASE_ITEMS);
        settle();
        configure(0, 0, 0, 3);
        random_phase(PHASE_ITEMS);
        settle();
        configure(13'($urandom_range(1, 8)), 13'($urandom_range(17, 31)),
                  13'($urandom_range(0, 20)), 13'($urandom_range(1, 5)));
        random_phase(PHASE_ITEMS);
        settle();
        configure(13'($urandom_range(1, 6)), 13'($urandom_range(1, 16)),
                  13'($urandom_range(0, 30)), 13'($urandom_range(0, 8)));
        random_phase(PHASE_ITEMS);
        settle();
        configure(5, 3, 2, 3);
        random_phase(PHASE_ITEMS);
        settle();

        if (pixels_due.size() != 0) begin
            $display("%0d expected pixels never arrived", pixels_due.size());
            fail_count += pixels_due.size();
        end
        $display("covered %0d items (%0d transmission events) over %0d register settings",
                 items_sent, tx_seen, settings_used);
        $display("%0d pixels checked, %0d of them period-marked, %0d register writes",
                 pixels_checked, marked_seen, cfg_writes);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sfad_pkg.sv
sv/spectrum_frame_average_decimate_top.sv
sv/sfad_checker.sv
tb/testbench.sv
